// ===== rtl/core/trigger_number_extender_unit_assert.svh =====
// Assertion macros for the trigger number extender unit.
// Included by files that check their own logic; needs no package.
`ifndef TRIGGER_NUMBER_EXTENDER_UNIT_ASSERT_SVH
`define TRIGGER_NUMBER_EXTENDER_UNIT_ASSERT_SVH

// same-cycle implication
`define TNE_ASSERT_NOW(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("trigger number extender check failed");

// next-cycle implication
`define TNE_ASSERT_NEXT(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("trigger number extender check failed");

`endif

// ===== rtl/core/tne_pkg.sv =====
// Shared types and constants of the trigger number extender.
// No dependencies.
package tne_pkg;

  localparam int NUM_W     = 32;
  localparam int KIND_W    = 2;
  localparam int OVW_W     = 16;
  localparam int JW_W      = 16;
  localparam int SL_W      = 15;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int BUF_CNT_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_SENT      = 2'd0,
    KIND_RECOVERED = 2'd1,
    KIND_DROPPED   = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_JUMP_WINDOW = 1'b0,
    CFG_SMALL_LIMIT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic valid;
    logic room;
    logic multi;
  } buf_status_t;

endpackage

// ===== rtl/core/tne_in_if.sv =====
// Input channel of the trigger number extender: frame tag and low counter.
// Depends on nothing.
interface tne_in_if #(
  parameter int TAG_BITS = 16,
  parameter int LOW_BITS = 15
);
  logic                valid;
  logic                ready;
  logic [TAG_BITS-1:0] frame_tag;
  logic [LOW_BITS-1:0] trigger_low;

  modport source (output valid, output frame_tag, output trigger_low, input ready);
  modport sink   (input valid, input frame_tag, input trigger_low, output ready);
endinterface

// ===== rtl/core/tne_out_if.sv =====
// Result channel of the trigger number extender.
// Depends on tne_pkg.
interface tne_out_if #(
  parameter int TAG_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic [tne_pkg::KIND_W-1:0]   kind;
  logic [TAG_BITS-1:0]          out_tag;
  logic [tne_pkg::NUM_W-1:0]    trigger_number;
  logic [tne_pkg::OVW_W-1:0]    overwrites;
  logic                         last;

  modport source (output valid, output kind, output out_tag, output trigger_number,
                  output overwrites, output last, input ready);
  modport sink   (input valid, input kind, input out_tag, input trigger_number,
                  input overwrites, input last, output ready);
endinterface

// ===== rtl/core/trigger_number_extender_unit.sv =====
// Trigger number extender: top level with input stage, decision logic and state.
// Depends on tne_pkg, tne_in_if, tne_out_if, tne_res_buf and the assertion header.
//
// Usage:
// - in_ch carries one frame per transfer: frame tag and low trigger counter.
// - out_ch carries results: kind, tag, 32-bit trigger number, overwrite count
//   and a last flag on the final result of each frame.
// - cfg_we_i/cfg_idx_i/cfg_data_i write jump_window (0) and small_limit (1);
//   write only while the block is idle.
// Timing:
// - One frame per cycle is accepted in steady state, while the result buffer has room.
// - A frame is decided once it sits in the input register and the buffer has room;
//   its first result is written to the result buffer and offered on out_ch from there.
// - A frame with a held predecessor yields two results; a broken frame yields none.
// - Throughput is set by the three-entry result buffer: the decision stage
//   runs only while the buffer holds at most one result.
// Reset clears the expectation (the next frame seeds it), drops any held
// frame, empties the result buffer and restores the register defaults.
// When out_ch stalls, the buffer fills, the decision stage waits and in_ch
// drops ready once its input register is occupied; nothing is lost.
`include "trigger_number_extender_unit_assert.svh"

module trigger_number_extender_unit #(
  parameter int LOW_BITS = 15,
  parameter int TAG_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tne_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tne_pkg::CFG_W-1:0]     cfg_data_i,
  tne_in_if.sink                        in_ch,
  tne_out_if.source                     out_ch
);

  localparam int NumW = tne_pkg::NUM_W;
  localparam logic [NumW-1:0] BlockStep = NumW'(64'd1 << LOW_BITS);

  typedef struct packed {
    logic [tne_pkg::KIND_W-1:0] kind;
    logic [TAG_BITS-1:0]        tag;
    logic [NumW-1:0]            number;
    logic [tne_pkg::OVW_W-1:0]  ovw;
    logic                       last;
  } res_t;

  logic [tne_pkg::JW_W-1:0] jump_window_q;
  logic [tne_pkg::SL_W-1:0] small_limit_q;

  logic                in_vq;
  logic [TAG_BITS-1:0] in_tag_q;
  logic [LOW_BITS-1:0] in_low_q;

  logic [NumW-1:0]           exp_q, exp_d, last_q, last_d;
  logic                      wait_first_q;
  logic                      held_valid_q, held_valid_d;
  logic [TAG_BITS-1:0]       held_tag_q, held_tag_d;
  logic [LOW_BITS-1:0]       held_low_q, held_low_d;
  logic [tne_pkg::OVW_W-1:0] ovw_q, ovw_d;

  tne_pkg::buf_status_t          buf_st;
  logic [tne_pkg::BUF_CNT_W-1:0] push_cnt;
  res_t                          r0, r1, head;
  logic                          proc_go, pop;

  logic [NumW-1:0] exp0, exp1, g0, g1, diff0, diff1;
  logic            hv0, mismatch, small_low, fit0, fit1, brk;

  assign proc_go     = in_vq && buf_st.room;
  assign in_ch.ready = !in_vq || proc_go;
  assign pop         = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jump_window_q <= tne_pkg::JW_W'(20);
      small_limit_q <= tne_pkg::SL_W'(8);
    end else if (cfg_we_i) begin
      unique case (tne_pkg::cfg_idx_e'(cfg_idx_i))
        tne_pkg::CFG_JUMP_WINDOW: jump_window_q <= cfg_data_i[tne_pkg::JW_W-1:0];
        tne_pkg::CFG_SMALL_LIMIT: small_limit_q <= cfg_data_i[tne_pkg::SL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_vq <= 1'b1;
    end else if (proc_go) begin
      in_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      in_tag_q <= in_ch.frame_tag;
      in_low_q <= in_ch.trigger_low;
    end
  end

  always_comb begin
    exp0      = wait_first_q ? NumW'(in_low_q) : exp_q;
    hv0       = wait_first_q ? 1'b0 : held_valid_q;
    mismatch  = (in_low_q != exp0[LOW_BITS-1:0]);
    small_low = (NumW'(in_low_q) <= NumW'(small_limit_q));
    g0        = {exp0[NumW-1:LOW_BITS], in_low_q};
    g1        = g0 + BlockStep;
    diff0     = g0 - exp0;
    diff1     = g1 - exp0;
    fit0      = (g0 > exp0) && (diff0 < NumW'(jump_window_q));
    fit1      = (g1 > exp0) && (diff1 < NumW'(jump_window_q));
    brk       = mismatch && (small_low || !(fit0 || fit1));
    exp1      = !mismatch ? exp0 : (fit0 ? g0 : g1);

    exp_d        = exp_q;
    last_d       = last_q;
    held_valid_d = held_valid_q;
    held_tag_d   = held_tag_q;
    held_low_d   = held_low_q;
    ovw_d        = ovw_q;
    if (brk) begin
      if (hv0 && (ovw_q != '1)) begin
        ovw_d = ovw_q + tne_pkg::OVW_W'(1);
      end
      held_valid_d = 1'b1;
      held_tag_d   = in_tag_q;
      held_low_d   = in_low_q;
      exp_d        = exp0 + NumW'(1);
    end else begin
      held_valid_d = 1'b0;
      last_d       = exp1;
      exp_d        = exp1 + NumW'(1);
    end

    r1.kind   = tne_pkg::KIND_SENT;
    r1.tag    = in_tag_q;
    r1.number = exp1;
    r1.ovw    = ovw_q;
    r1.last   = 1'b1;
    r0.tag    = held_tag_q;
    r0.ovw    = ovw_q;
    r0.last   = 1'b0;
    if (last_q + NumW'(2) == exp1) begin
      r0.kind   = tne_pkg::KIND_RECOVERED;
      r0.number = last_q + NumW'(1);
    end else begin
      r0.kind   = tne_pkg::KIND_DROPPED;
      r0.number = NumW'(held_low_q);
    end
    if (!hv0) begin
      r0 = r1;
    end

    if (!proc_go || brk) begin
      push_cnt = '0;
    end else if (hv0) begin
      push_cnt = tne_pkg::BUF_CNT_W'(2);
    end else begin
      push_cnt = tne_pkg::BUF_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q        <= '0;
      last_q       <= '0;
      wait_first_q <= 1'b1;
      held_valid_q <= 1'b0;
      held_tag_q   <= '0;
      held_low_q   <= '0;
      ovw_q        <= '0;
    end else if (proc_go) begin
      exp_q        <= exp_d;
      last_q       <= last_d;
      wait_first_q <= 1'b0;
      held_valid_q <= held_valid_d;
      held_tag_q   <= held_tag_d;
      held_low_q   <= held_low_d;
      ovw_q        <= ovw_d;
    end
  end

  tne_res_buf #(
    .W($bits(res_t))
  ) u_res_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_cnt_i(push_cnt),
    .push0_i   (r0),
    .push1_i   (r1),
    .pop_i     (pop),
    .head_o    (head),
    .status_o  (buf_st)
  );

  assign out_ch.valid          = buf_st.valid;
  assign out_ch.kind           = head.kind;
  assign out_ch.out_tag        = head.tag;
  assign out_ch.trigger_number = head.number;
  assign out_ch.overwrites     = head.ovw;
  assign out_ch.last           = head.last;

  `TNE_ASSERT_NOW(a_held_not_waiting, clk_i, rst_ni, held_valid_q, !wait_first_q)
  `TNE_ASSERT_NEXT(a_seeded_after_go, clk_i, rst_ni, proc_go, !wait_first_q)
  `TNE_ASSERT_NOW(a_held_result_paired, clk_i, rst_ni,
                  out_ch.valid && (out_ch.kind != tne_pkg::KIND_SENT),
                  buf_st.multi && !out_ch.last)
  `TNE_ASSERT_NEXT(a_broken_is_held, clk_i, rst_ni, proc_go && brk, held_valid_q)

endmodule

// ===== rtl/core/tne_res_buf.sv =====
// Three-entry result buffer, up to two writes and one read per cycle.
// Depends on tne_pkg.
module tne_res_buf #(
  parameter int W = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [tne_pkg::BUF_CNT_W-1:0] push_cnt_i,
  input  logic [W-1:0]                  push0_i,
  input  logic [W-1:0]                  push1_i,
  input  logic                          pop_i,
  output logic [W-1:0]                  head_o,
  output tne_pkg::buf_status_t          status_o
);

  localparam int Depth = 3;

  logic [W-1:0]                  res_q [Depth];
  logic [W-1:0]                  res_d [Depth];
  logic [tne_pkg::BUF_CNT_W-1:0] cnt_q, cnt_d, base;

  always_comb begin
    res_d = res_q;
    if (pop_i) begin
      res_d[0] = res_q[1];
      res_d[1] = res_q[2];
    end
    base = cnt_q - {{(tne_pkg::BUF_CNT_W-1){1'b0}}, pop_i};
    if (push_cnt_i != '0) begin
      res_d[base] = push0_i;
    end
    if (push_cnt_i == tne_pkg::BUF_CNT_W'(2)) begin
      res_d[base + tne_pkg::BUF_CNT_W'(1)] = push1_i;
    end
    cnt_d = base + push_cnt_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign head_o         = res_q[0];
  assign status_o.valid = (cnt_q != '0);
  assign status_o.room  = (cnt_q <= tne_pkg::BUF_CNT_W'(1));
  assign status_o.multi = (cnt_q >= tne_pkg::BUF_CNT_W'(2));

endmodule
